/* rtl/bmb_pkg.sv */
// bmb_pkg: shared constants for the billboard matrix builder
// no dependencies; used by bmb_norm, billboard_matrix_builder and bmb_check
package bmb_pkg;

   localparam int FRAC_BITS_DEF = 16;

   // root bits resolved per square-root stage, quotient bits per divide stage
   localparam int SQRT_STEPS = 4;
   localparam int DIV_STEPS  = 4;

   localparam logic MODE_SPHERICAL   = 1'b0;
   localparam logic MODE_CYLINDRICAL = 1'b1;

   localparam logic [1:0] ROW_RIGHT = 2'd0;
   localparam logic [1:0] ROW_UP    = 2'd1;
   localparam logic [1:0] ROW_LOOK  = 2'd2;
   localparam logic [1:0] ROW_POS   = 2'd3;

endpackage

/* rtl/billboard_matrix_builder.sv */
// billboard_matrix_builder: billboard transform rows from position, camera and up/axis
// depends on bmb_pkg and bmb_norm
//
//   channel   ports                       direction   beat
//   req       req_valid / req_stall       in          one object: mode, pos, cam, aux
//   rsp       rsp_valid / rsp_stall       out         one matrix row, four per object
//
// a req beat passes the difference registers, the first normalize slot, cross product
// registers, the second slot, cross product registers, the third slot, the serializer
// the four-beat row serializer sets the sustained object rate
// reset clears every valid bit and the serializer; payload registers are not reset
// the whole pipeline freezes while a finished object waits for the serializer
module billboard_matrix_builder #(
   parameter int FRAC_BITS = bmb_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic [31:0] req_cam_x,
   input  logic [31:0] req_cam_y,
   input  logic [31:0] req_cam_z,
   input  logic [31:0] req_aux_x,
   input  logic [31:0] req_aux_y,
   input  logic [31:0] req_aux_z,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_row_index,
   output logic [31:0] rsp_elem_a,
   output logic [31:0] rsp_elem_b,
   output logic [31:0] rsp_elem_c,
   output logic [31:0] rsp_elem_d,
   output logic        rsp_degenerate,
   output logic        rsp_last_row
);

   localparam int LW  = FRAC_BITS + 2;
   localparam int P1W = 32 + LW;
   localparam int W1  = P1W + 1;
   localparam int P2W = 2 * LW;
   localparam int W2  = P2W + 1;
   localparam logic [31:0] ONE_VAL = 32'(1) << FRAC_BITS;

   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] aux;
   } side_a_type;

   typedef struct packed {
      logic             act;
      logic [2:0][31:0] pos;
      logic [2:0][LW-1:0] look0;
      logic [2:0][LW-1:0] up;
      logic             deg;
   } side_b_type;

   typedef struct packed {
      logic             act;
      logic [2:0][31:0] pos;
      logic [2:0][LW-1:0] look0;
      logic [2:0][LW-1:0] up;
      logic [2:0][LW-1:0] right;
      logic             deg;
   } side_c_type;

   logic adv;
   logic load;
   logic rsp_beat;

   // input and difference stages
   logic             v0_ff, act0_ff;
   logic [2:0][31:0] pos0_ff, cam0_ff, aux0_ff;
   logic             v1_ff, act1_ff;
   logic [2:0][31:0] pos1_ff, aux1_ff;
   logic [2:0][32:0] d1_ff, d1_in;

   // first normalize slot
   side_a_type         sa_in, sa_out;
   logic               na_valid, na_deg, nu_valid, nu_deg, nu_act;
   logic [2:0][LW-1:0] na_vec, nu_vec;

   // aux x look0
   logic               v2_ff, act2_ff, deg2_ff;
   logic [2:0][31:0]   pos2_ff;
   logic [2:0][LW-1:0] look02_ff, up2_ff;
   logic signed [P1W-1:0] pp2_ff [3];
   logic signed [P1W-1:0] pm2_ff [3];
   logic signed [P1W-1:0] pp2_in [3];
   logic signed [P1W-1:0] pm2_in [3];
   logic               v3_ff;
   side_b_type         sb3_ff;
   logic [2:0][W1-1:0] cr1_ff, cr1_in;

   // second normalize slot
   side_b_type         sb_out;
   logic               nb_valid, nb_deg;
   logic [2:0][LW-1:0] nb_vec;

   // second cross product
   logic               v4_ff;
   side_c_type         sc4_ff, sc4_in;
   logic [2:0][LW-1:0] ma, mb;
   logic signed [P2W-1:0] pp4_ff [3];
   logic signed [P2W-1:0] pm4_ff [3];
   logic signed [P2W-1:0] pp4_in [3];
   logic signed [P2W-1:0] pm4_in [3];
   logic               v5_ff;
   side_c_type         sc5_ff;
   logic [2:0][W2-1:0] cr2_ff, cr2_in;

   // third normalize slot
   side_c_type         sc_out;
   logic               nc_valid, nc_deg;
   logic [2:0][LW-1:0] nc_vec;

   // row serializer
   logic               hold_v_ff;
   logic [1:0]         row_ff;
   logic [2:0][LW-1:0] right_ff, up_ff, look_ff, right_in, up_in, look_in;
   logic [2:0][31:0]   pos_ff;
   logic               deg_ff;

   assign rsp_beat  = hold_v_ff & ~rsp_stall;
   assign load      = nc_valid & (~hold_v_ff | (rsp_beat & (row_ff == bmb_pkg::ROW_POS)));
   assign adv       = ~nc_valid | load;
   assign req_stall = ~adv;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d1_in[i] = {cam0_ff[i][31], cam0_ff[i]} - {pos0_ff[i][31], pos0_ff[i]};
      end
   end

   assign sa_in.pos = pos1_ff;
   assign sa_in.aux = aux1_ff;

   bmb_norm #(.IN_W(33), .FRAC_BITS(FRAC_BITS), .SIDE_W($bits(side_a_type))) u_norm_look (
      .clock(clock), .reset(reset), .en(adv), .in_valid(v1_ff), .in_vec(d1_ff),
      .side_in(sa_in), .out_valid(na_valid), .out_vec(na_vec), .out_deg(na_deg),
      .side_out(sa_out)
   );

   bmb_norm #(.IN_W(32), .FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_norm_axis (
      .clock(clock), .reset(reset), .en(adv), .in_valid(v1_ff), .in_vec(aux1_ff),
      .side_in(act1_ff), .out_valid(nu_valid), .out_vec(nu_vec), .out_deg(nu_deg),
      .side_out(nu_act)
   );

   // cross(a, b)[i] = a[i+1] * b[i+2] - a[i+2] * b[i+1]
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pp2_in[i] = $signed(sa_out.aux[(i+1)%3]) * $signed(na_vec[(i+2)%3]);
         pm2_in[i] = $signed(sa_out.aux[(i+2)%3]) * $signed(na_vec[(i+1)%3]);
         cr1_in[i] = W1'(pp2_ff[i]) - W1'(pm2_ff[i]);
      end
   end

   bmb_norm #(.IN_W(W1), .FRAC_BITS(FRAC_BITS), .SIDE_W($bits(side_b_type))) u_norm_right (
      .clock(clock), .reset(reset), .en(adv), .in_valid(v3_ff), .in_vec(cr1_ff),
      .side_in(sb3_ff), .out_valid(nb_valid), .out_vec(nb_vec), .out_deg(nb_deg),
      .side_out(sb_out)
   );

   // spherical: look x right gives up; cylindrical: right x up gives look
   always_comb begin
      if (sb_out.act == bmb_pkg::MODE_CYLINDRICAL) begin
         ma = nb_vec;
         mb = sb_out.up;
      end else begin
         ma = sb_out.look0;
         mb = nb_vec;
      end
      for (int i = 0; i < 3; i++) begin
         pp4_in[i] = $signed(ma[(i+1)%3]) * $signed(mb[(i+2)%3]);
         pm4_in[i] = $signed(ma[(i+2)%3]) * $signed(mb[(i+1)%3]);
         cr2_in[i] = W2'(pp4_ff[i]) - W2'(pm4_ff[i]);
      end
      sc4_in.act   = sb_out.act;
      sc4_in.pos   = sb_out.pos;
      sc4_in.look0 = sb_out.look0;
      sc4_in.up    = sb_out.up;
      sc4_in.right = nb_vec;
      sc4_in.deg   = sb_out.deg | nb_deg;
   end

   bmb_norm #(.IN_W(W2), .FRAC_BITS(FRAC_BITS), .SIDE_W($bits(side_c_type))) u_norm_last (
      .clock(clock), .reset(reset), .en(adv), .in_valid(v5_ff), .in_vec(cr2_ff),
      .side_in(sc5_ff), .out_valid(nc_valid), .out_vec(nc_vec), .out_deg(nc_deg),
      .side_out(sc_out)
   );

   always_comb begin
      right_in = sc_out.right;
      if (sc_out.act == bmb_pkg::MODE_CYLINDRICAL) begin
         up_in   = sc_out.up;
         look_in = nc_vec;
      end else begin
         up_in   = nc_vec;
         look_in = sc_out.look0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_valid;
         v1_ff <= v0_ff;
         v2_ff <= na_valid & nu_valid;
         v3_ff <= v2_ff;
         v4_ff <= nb_valid;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         act0_ff    <= req_action;
         pos0_ff    <= {req_pos_z, req_pos_y, req_pos_x};
         cam0_ff    <= {req_cam_z, req_cam_y, req_cam_x};
         aux0_ff    <= {req_aux_z, req_aux_y, req_aux_x};
         act1_ff    <= act0_ff;
         pos1_ff    <= pos0_ff;
         aux1_ff    <= aux0_ff;
         d1_ff      <= d1_in;
         act2_ff    <= nu_act;
         pos2_ff    <= sa_out.pos;
         look02_ff  <= na_vec;
         up2_ff     <= nu_vec;
         // the axis only counts in cylindrical mode
         deg2_ff    <= na_deg | ((nu_act == bmb_pkg::MODE_CYLINDRICAL) & nu_deg);
         for (int i = 0; i < 3; i++) begin
            pp2_ff[i] <= pp2_in[i];
            pm2_ff[i] <= pm2_in[i];
            pp4_ff[i] <= pp4_in[i];
            pm4_ff[i] <= pm4_in[i];
         end
         sb3_ff.act   <= act2_ff;
         sb3_ff.pos   <= pos2_ff;
         sb3_ff.look0 <= look02_ff;
         sb3_ff.up    <= up2_ff;
         sb3_ff.deg   <= deg2_ff;
         cr1_ff       <= cr1_in;
         sc4_ff       <= sc4_in;
         sc5_ff       <= sc4_ff;
         cr2_ff       <= cr2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         row_ff    <= bmb_pkg::ROW_RIGHT;
      end else if (load) begin
         hold_v_ff <= 1'b1;
         row_ff    <= bmb_pkg::ROW_RIGHT;
      end else if (rsp_beat) begin
         if (row_ff == bmb_pkg::ROW_POS) begin
            hold_v_ff <= 1'b0;
         end
         row_ff <= row_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         right_ff <= right_in;
         up_ff    <= up_in;
         look_ff  <= look_in;
         pos_ff   <= sc_out.pos;
         deg_ff   <= sc_out.deg | nc_deg;
      end
   end

   always_comb begin
      rsp_elem_d = '0;
      unique case (row_ff)
         bmb_pkg::ROW_RIGHT: begin
            rsp_elem_a = 32'($signed(right_ff[0]));
            rsp_elem_b = 32'($signed(right_ff[1]));
            rsp_elem_c = 32'($signed(right_ff[2]));
         end
         bmb_pkg::ROW_UP: begin
            rsp_elem_a = 32'($signed(up_ff[0]));
            rsp_elem_b = 32'($signed(up_ff[1]));
            rsp_elem_c = 32'($signed(up_ff[2]));
         end
         bmb_pkg::ROW_LOOK: begin
            rsp_elem_a = 32'($signed(look_ff[0]));
            rsp_elem_b = 32'($signed(look_ff[1]));
            rsp_elem_c = 32'($signed(look_ff[2]));
         end
         default: begin
            rsp_elem_a = pos_ff[0];
            rsp_elem_b = pos_ff[1];
            rsp_elem_c = pos_ff[2];
            rsp_elem_d = ONE_VAL;
         end
      endcase
   end

   assign rsp_valid      = hold_v_ff;
   assign rsp_row_index  = row_ff;
   assign rsp_degenerate = deg_ff;
   assign rsp_last_row   = (row_ff == bmb_pkg::ROW_POS);

endmodule

/* rtl/bmb_norm.sv */
// bmb_norm: pipelined normalizer for a signed 3-vector, sideband carried alongside
// depends on bmb_pkg (step counts per stage)
module bmb_norm #(
   parameter int IN_W      = 33,
   parameter int FRAC_BITS = bmb_pkg::FRAC_BITS_DEF,
   parameter int SIDE_W    = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [2:0][IN_W-1:0]      in_vec,
   input  logic [SIDE_W-1:0]         side_in,
   output logic                      out_valid,
   output logic [2:0][FRAC_BITS+1:0] out_vec,
   output logic                      out_deg,
   output logic [SIDE_W-1:0]         side_out
);

   localparam int MW    = (IN_W > 30) ? IN_W : 30;
   localparam int PW    = $clog2(MW);
   localparam int QW    = FRAC_BITS + 1;
   localparam int NW    = 31 + FRAC_BITS;
   localparam int LW    = FRAC_BITS + 2;
   localparam int SQ_N  = bmb_pkg::SQRT_STEPS;
   localparam int SQ_ST = 32 / SQ_N;
   localparam int DV_N  = bmb_pkg::DIV_STEPS;
   localparam int DV_ST = (QW + DV_N - 1) / DV_N;
   localparam logic [PW-1:0] TOP_BIT = PW'(29);

   typedef struct packed {
      logic [SIDE_W-1:0] side;
      logic              zero;
      logic [2:0]        neg;
   } tag_type;

   // stage 1: sign and magnitude
   logic                 v1_ff;
   logic [2:0][MW-1:0]   mag1_ff, mag1_in;
   logic [2:0]           neg1_ff, neg1_in;
   logic [SIDE_W-1:0]    side1_ff;
   // stage 2: leading one of the largest magnitude
   logic                 v2_ff;
   logic [2:0][MW-1:0]   mag2_ff;
   tag_type              tag2_ff, tag2_in;
   logic [PW-1:0]        p2_ff, p2_in;
   // stage 3: scaled magnitudes
   logic                 v3_ff;
   tag_type              tag3_ff;
   logic [2:0][29:0]     sm3_ff, sm3_in;
   // stage 4: squares
   logic                 v4_ff;
   tag_type              tag4_ff;
   logic [2:0][29:0]     sm4_ff;
   logic [2:0][59:0]     sq4_ff, sq4_in;
   // stage 5: sum of squares
   logic                 v5_ff;
   tag_type              tag5_ff;
   logic [2:0][29:0]     sm5_ff;
   logic [61:0]          sum5_ff, sum5_in;
   // square root stages
   logic                 vq_ff    [SQ_ST];
   tag_type              tagq_ff  [SQ_ST];
   logic [2:0][29:0]     smq_ff   [SQ_ST];
   logic [63:0]          xq_ff    [SQ_ST];
   logic [63:0]          xq_in    [SQ_ST];
   logic [35:0]          remq_ff  [SQ_ST];
   logic [35:0]          remq_in  [SQ_ST];
   logic [31:0]          rootq_ff [SQ_ST];
   logic [31:0]          rootq_in [SQ_ST];
   // divide setup
   logic                 vp_ff;
   tag_type              tagp_ff;
   logic [2:0][NW-1:0]   nump_ff, nump_in;
   logic [31:0]          lenp_ff;
   // divide stages
   logic                 vd_ff    [DV_ST];
   tag_type              tagd_ff  [DV_ST];
   logic [2:0][32:0]     remd_ff  [DV_ST];
   logic [2:0][32:0]     remd_in  [DV_ST];
   logic [2:0][QW-1:0]   lowd_ff  [DV_ST];
   logic [2:0][QW-1:0]   lowd_in  [DV_ST];
   logic [2:0][QW-1:0]   qd_ff    [DV_ST];
   logic [2:0][QW-1:0]   qd_in    [DV_ST];
   logic [31:0]          lend_ff  [DV_ST];
   // output stage
   logic                 vo_ff;
   logic [2:0][LW-1:0]   out_ff, out_in;
   logic                 deg_ff;
   logic [SIDE_W-1:0]    sideo_ff;

   always_comb begin
      logic [IN_W-1:0] absv;
      absv = '0;
      for (int i = 0; i < 3; i++) begin
         neg1_in[i] = in_vec[i][IN_W-1];
         absv       = neg1_in[i] ? (~in_vec[i] + IN_W'(1)) : in_vec[i];
         mag1_in[i] = MW'(absv);
      end
   end

   // msb of the largest equals msb of the or of all three
   always_comb begin
      logic [MW-1:0] orv;
      orv   = mag1_ff[0] | mag1_ff[1] | mag1_ff[2];
      p2_in = '0;
      for (int b = 0; b < MW; b++) begin
         if (orv[b]) begin
            p2_in = PW'(b);
         end
      end
      tag2_in.side = side1_ff;
      tag2_in.zero = ~|orv;
      tag2_in.neg  = neg1_ff;
   end

   always_comb begin
      logic [MW-1:0] sh;
      sh = '0;
      for (int i = 0; i < 3; i++) begin
         if (p2_ff >= TOP_BIT) begin
            sh = mag2_ff[i] >> (p2_ff - TOP_BIT);
         end else begin
            sh = mag2_ff[i] << (TOP_BIT - p2_ff);
         end
         sm3_in[i] = sh[29:0];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq4_in[i] = 60'(sm3_ff[i]) * 60'(sm3_ff[i]);
      end
      sum5_in = 62'(sq4_ff[0]) + 62'(sq4_ff[1]) + 62'(sq4_ff[2]);
   end

   // restoring square root, two radicand bits per step
   always_comb begin
      logic [63:0] x;
      logic [35:0] rem;
      logic [35:0] trial;
      logic [31:0] root;
      x     = '0;
      rem   = '0;
      trial = '0;
      root  = '0;
      for (int k = 0; k < SQ_ST; k++) begin
         if (k == 0) begin
            x    = 64'(sum5_ff);
            rem  = '0;
            root = '0;
         end else begin
            x    = xq_ff[(k == 0) ? 0 : k-1];
            rem  = remq_ff[(k == 0) ? 0 : k-1];
            root = rootq_ff[(k == 0) ? 0 : k-1];
         end
         for (int s = 0; s < SQ_N; s++) begin
            rem   = {rem[33:0], x[63:62]};
            x     = {x[61:0], 2'b00};
            trial = {2'b00, root, 2'b01};
            if (rem >= trial) begin
               rem  = rem - trial;
               root = {root[30:0], 1'b1};
            end else begin
               root = {root[30:0], 1'b0};
            end
         end
         xq_in[k]    = x;
         remq_in[k]  = rem;
         rootq_in[k] = root;
      end
   end

   // numerator carries half the length for round half up
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nump_in[i] = (NW'(smq_ff[SQ_ST-1][i]) << FRAC_BITS)
                    + NW'(rootq_ff[SQ_ST-1] >> 1);
      end
   end

   // restoring divide; the quotient never exceeds QW bits
   always_comb begin
      logic [32:0]   rem;
      logic [QW-1:0] low;
      logic [QW-1:0] q;
      logic [31:0]   len;
      rem = '0;
      low = '0;
      q   = '0;
      len = '0;
      for (int j = 0; j < DV_ST; j++) begin
         for (int i = 0; i < 3; i++) begin
            if (j == 0) begin
               rem = 33'(nump_ff[i][NW-1:QW]);
               low = nump_ff[i][QW-1:0];
               q   = '0;
               len = lenp_ff;
            end else begin
               rem = remd_ff[(j == 0) ? 0 : j-1][i];
               low = lowd_ff[(j == 0) ? 0 : j-1][i];
               q   = qd_ff[(j == 0) ? 0 : j-1][i];
               len = lend_ff[(j == 0) ? 0 : j-1];
            end
            for (int s = 0; s < DV_N; s++) begin
               if (j * DV_N + s < QW) begin
                  rem = {rem[31:0], low[QW-1]};
                  low = {low[QW-2:0], 1'b0};
                  if (rem >= {1'b0, len}) begin
                     rem = rem - {1'b0, len};
                     q   = {q[QW-2:0], 1'b1};
                  end else begin
                     q   = {q[QW-2:0], 1'b0};
                  end
               end
            end
            remd_in[j][i] = rem;
            lowd_in[j][i] = low;
            qd_in[j][i]   = q;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (tagd_ff[DV_ST-1].zero) begin
            out_in[i] = '0;
         end else if (tagd_ff[DV_ST-1].neg[i]) begin
            out_in[i] = -LW'(qd_ff[DV_ST-1][i]);
         end else begin
            out_in[i] = LW'(qd_ff[DV_ST-1][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         vp_ff <= 1'b0;
         vo_ff <= 1'b0;
         for (int k = 0; k < SQ_ST; k++) begin
            vq_ff[k] <= 1'b0;
         end
         for (int j = 0; j < DV_ST; j++) begin
            vd_ff[j] <= 1'b0;
         end
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         for (int k = 0; k < SQ_ST; k++) begin
            vq_ff[k] <= (k == 0) ? v5_ff : vq_ff[(k == 0) ? 0 : k-1];
         end
         vp_ff <= vq_ff[SQ_ST-1];
         for (int j = 0; j < DV_ST; j++) begin
            vd_ff[j] <= (j == 0) ? vp_ff : vd_ff[(j == 0) ? 0 : j-1];
         end
         vo_ff <= vd_ff[DV_ST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag1_ff  <= mag1_in;
         neg1_ff  <= neg1_in;
         side1_ff <= side_in;
         mag2_ff  <= mag1_ff;
         tag2_ff  <= tag2_in;
         p2_ff    <= p2_in;
         tag3_ff  <= tag2_ff;
         sm3_ff   <= sm3_in;
         tag4_ff  <= tag3_ff;
         sm4_ff   <= sm3_ff;
         sq4_ff   <= sq4_in;
         tag5_ff  <= tag4_ff;
         sm5_ff   <= sm4_ff;
         sum5_ff  <= sum5_in;
         for (int k = 0; k < SQ_ST; k++) begin
            tagq_ff[k]  <= (k == 0) ? tag5_ff : tagq_ff[(k == 0) ? 0 : k-1];
            smq_ff[k]   <= (k == 0) ? sm5_ff  : smq_ff[(k == 0) ? 0 : k-1];
            xq_ff[k]    <= xq_in[k];
            remq_ff[k]  <= remq_in[k];
            rootq_ff[k] <= rootq_in[k];
         end
         tagp_ff <= tagq_ff[SQ_ST-1];
         nump_ff <= nump_in;
         lenp_ff <= rootq_ff[SQ_ST-1];
         for (int j = 0; j < DV_ST; j++) begin
            tagd_ff[j] <= (j == 0) ? tagp_ff : tagd_ff[(j == 0) ? 0 : j-1];
            lend_ff[j] <= (j == 0) ? lenp_ff : lend_ff[(j == 0) ? 0 : j-1];
            remd_ff[j] <= remd_in[j];
            lowd_ff[j] <= lowd_in[j];
            qd_ff[j]   <= qd_in[j];
         end
         out_ff   <= out_in;
         deg_ff   <= tagd_ff[DV_ST-1].zero;
         sideo_ff <= tagd_ff[DV_ST-1].side;
      end
   end

   assign out_valid = vo_ff;
   assign out_vec   = out_ff;
   assign out_deg   = deg_ff;
   assign side_out  = sideo_ff;

endmodule

/* rtl/bmb_check.sv */
// bmb_check: port-level checks on the row stream of billboard_matrix_builder
// depends on bmb_pkg; bound to the top level at the end of this file
module bmb_check (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_row_index,
   input logic [31:0] rsp_elem_a,
   input logic [31:0] rsp_elem_d,
   input logic        rsp_degenerate,
   input logic        rsp_last_row
);

   // last_row marks exactly the position row
   a_last_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_row == (rsp_row_index == bmb_pkg::ROW_POS)))
      else $error("last_row does not match row index");

   // rows of one matrix follow each other without a gap in numbering
   a_row_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_row |=>
         rsp_valid && (rsp_row_index == $past(rsp_row_index) + 2'd1))
      else $error("matrix rows out of order");

   // degenerate flag is one value for the whole matrix
   a_deg_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_row |=> $stable(rsp_degenerate))
      else $error("degenerate flag changed inside a matrix");

   a_elem_d: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_row |-> (rsp_elem_d == 32'd0))
      else $error("fourth element nonzero on a direction row");

   // a stalled beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_elem_a)
         && $stable(rsp_row_index))
      else $error("stalled beat changed");

endmodule

bind billboard_matrix_builder bmb_check u_bmb_check (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_row_index(rsp_row_index),
   .rsp_elem_a(rsp_elem_a),
   .rsp_elem_d(rsp_elem_d),
   .rsp_degenerate(rsp_degenerate),
   .rsp_last_row(rsp_last_row)
);

/* test/tb_billboard_matrix_builder.sv */
// tb_billboard_matrix_builder: checks billboard rows against an in-bench fixed point predictor
// depends on bmb_pkg and billboard_matrix_builder
`timescale 1ns / 1ps
module tb_billboard_matrix_builder;

   localparam int FB = bmb_pkg::FRAC_BITS_DEF;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [1:0]  row;
      logic [31:0] a, b, c, d;
      logic        deg, last;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_action = 1'b0;
   logic [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic [31:0] req_cam_x = '0, req_cam_y = '0, req_cam_z = '0;
   logic [31:0] req_aux_x = '0, req_aux_y = '0, req_aux_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_row_index;
   logic [31:0] rsp_elem_a, rsp_elem_b, rsp_elem_c, rsp_elem_d;
   logic rsp_degenerate, rsp_last_row;

   row_type expected_rows[$];
   int   errors = 0;
   int   idle_cycles = 0;
   int   stall_left = 0;
   bit   idling_on = 1'b1;

   always #4 clock = ~clock;

   billboard_matrix_builder DUT (.*);

   function automatic longint unsigned root64(longint unsigned x);
      longint unsigned r = 0, bit_v = 64'd1 << 62;
      while (bit_v > x) bit_v >>= 2;
      while (bit_v != 0) begin
         if (x >= r + bit_v) begin
            x -= r + bit_v;
            r = (r >> 1) + bit_v;
         end else begin
            r >>= 1;
         end
         bit_v >>= 2;
      end
      return r;
   endfunction

   // unit vector: scale magnitudes so the largest lands in [2^29, 2^30)
   task automatic unit_vec(input longint v[3], output longint o[3], inout bit deg);
      longint unsigned mag[3], m, sum, len, q;
      bit neg[3];
      m = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = v[i] < 0;
         mag[i] = neg[i] ? -v[i] : v[i];
         if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
         o = '{0, 0, 0};
         deg = 1'b1;
         return;
      end
      while (m >= (64'd1 << 30)) begin
         for (int i = 0; i < 3; i++) mag[i] >>= 1;
         m >>= 1;
      end
      while (m < (64'd1 << 29)) begin
         for (int i = 0; i < 3; i++) mag[i] <<= 1;
         m <<= 1;
      end
      sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      len = root64(sum);
      for (int i = 0; i < 3; i++) begin
         q = ((mag[i] << FB) + (len >> 1)) / len;
         o[i] = neg[i] ? -longint'(q) : longint'(q);
      end
   endtask

   function automatic void cross3(input longint a[3], input longint b[3],
                                  output longint o[3]);
      o[0] = a[1] * b[2] - a[2] * b[1];
      o[1] = a[2] * b[0] - a[0] * b[2];
      o[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   task automatic predict_matrix(input logic mode, input logic [31:0] p[3],
                                 input logic [31:0] cm[3], input logic [31:0] ax[3]);
      longint pos[3], aux[3], dir[3], tmp[3], rgt[3], up[3], look[3], look0[3];
      longint rows[4][3];
      bit deg;
      row_type r;
      deg = 1'b0;
      for (int i = 0; i < 3; i++) begin
         pos[i] = longint'($signed(p[i]));
         aux[i] = longint'($signed(ax[i]));
         dir[i] = longint'($signed(cm[i])) - pos[i];
      end
      if (mode == bmb_pkg::MODE_SPHERICAL) begin
         unit_vec(dir, look, deg);
         cross3(aux, look, tmp);
         unit_vec(tmp, rgt, deg);
         cross3(look, rgt, tmp);
         unit_vec(tmp, up, deg);
      end else begin
         unit_vec(dir, look0, deg);
         unit_vec(aux, up, deg);
         cross3(aux, look0, tmp);
         unit_vec(tmp, rgt, deg);
         cross3(rgt, up, tmp);
         unit_vec(tmp, look, deg);
      end
      rows[bmb_pkg::ROW_RIGHT] = rgt;
      rows[bmb_pkg::ROW_UP] = up;
      rows[bmb_pkg::ROW_LOOK] = look;
      rows[bmb_pkg::ROW_POS] = pos;
      for (int k = 0; k < 4; k++) begin
         r.row = k[1:0];
         r.a = rows[k][0][31:0];
         r.b = rows[k][1][31:0];
         r.c = rows[k][2][31:0];
         r.d = (k == bmb_pkg::ROW_POS) ? (32'd1 << FB) : 32'd0;
         r.deg = deg;
         r.last = (k == bmb_pkg::ROW_POS);
         expected_rows.push_back(r);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
      errors++;
   endtask

   // sends one object; valid stays up between back-to-back beats and drops in idle gaps
   task automatic send_object(input logic mode, input logic [31:0] p[3],
                              input logic [31:0] cm[3], input logic [31:0] ax[3]);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= mode;
      {req_pos_x, req_pos_y, req_pos_z} <= {p[0], p[1], p[2]};
      {req_cam_x, req_cam_y, req_cam_z} <= {cm[0], cm[1], cm[2]};
      {req_aux_x, req_aux_y, req_aux_z} <= {ax[0], ax[1], ax[2]};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_matrix(mode, p, cm, ax);
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
         2: return 32'h8000_0000;
         3: return 32'h7fff_ffff;
         4: return $urandom_range(0, 3) - 1;
         default: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      endcase
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_rows.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      logic [31:0] z3[3], one3[3], mx[3], mn[3], up3[3], c3[3];
      z3 = '{0, 0, 0};
      one3 = '{32'h10000, 0, 0};
      mx = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
      mn = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      up3 = '{0, 32'h10000, 0};
      c3 = '{0, 0, 32'h50000};
      send_object(bmb_pkg::MODE_SPHERICAL, z3, c3, up3);
      send_object(bmb_pkg::MODE_CYLINDRICAL, z3, c3, up3);
      send_object(bmb_pkg::MODE_SPHERICAL, z3, z3, up3);     // camera on object
      send_object(bmb_pkg::MODE_CYLINDRICAL, z3, z3, up3);
      send_object(bmb_pkg::MODE_SPHERICAL, z3, c3, z3);      // zero up vector
      send_object(bmb_pkg::MODE_CYLINDRICAL, z3, c3, z3);
      send_object(bmb_pkg::MODE_SPHERICAL, z3, c3, c3);      // up parallel to look
      send_object(bmb_pkg::MODE_CYLINDRICAL, z3, c3, c3);
      send_object(bmb_pkg::MODE_SPHERICAL, mn, mx, mx);
      send_object(bmb_pkg::MODE_CYLINDRICAL, mx, mn, mn);
      send_object(bmb_pkg::MODE_SPHERICAL, mx, mn, mx);
      send_object(bmb_pkg::MODE_CYLINDRICAL, mn, mx, one3);
      send_object(bmb_pkg::MODE_SPHERICAL, one3, '{1, 0, 0}, '{0, 1, 1});
      send_object(bmb_pkg::MODE_CYLINDRICAL, '{32'hffffffff, 0, 0}, '{1, 1, 1}, '{0, 0, 1});
      send_object(bmb_pkg::MODE_SPHERICAL, mx, z3, '{32'hffff_ffff, 32'h7fff_ffff, 2});
      wait_drained();
   endtask

   task automatic test_random(input int count);
      logic [31:0] p[3], cm[3], ax[3];
      for (int n = 0; n < count; n++) begin
         for (int i = 0; i < 3; i++) begin
            p[i] = rand_word();
            ax[i] = rand_word();
            // mostly keep the camera a modest distance away
            cm[i] = ($urandom_range(0, 3) != 0) ? p[i] + {{14{$urandom_range(0, 1) == 1}},
                    18'($urandom)} : rand_word();
         end
         if ($urandom_range(0, 15) == 0) cm = p;
         send_object(1'($urandom_range(0, 1)), p, cm, ax);
      end
   endtask

   // pause the sender until the pipeline is empty
   task automatic test_drain_pause();
      test_random(10);
      wait_drained();
      test_random(10);
   endtask

   // stall driver: random stall bursts, none in the last part
   always @(negedge clock) begin
      if (reset || !idling_on) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         if (stall_left == 1)
            rsp_stall <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= int'($urandom_range(1, 4));
      end
   end

   always @(posedge clock) begin
      row_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rows.size() == 0) begin
            report_mismatch("unexpected row beat", 32'(rsp_row_index), 32'd0);
         end else begin
            want = expected_rows.pop_front();
            if (rsp_row_index !== want.row)
               report_mismatch("row_index", 32'(rsp_row_index), 32'(want.row));
            if (rsp_elem_a !== want.a) report_mismatch("elem_a", rsp_elem_a, want.a);
            if (rsp_elem_b !== want.b) report_mismatch("elem_b", rsp_elem_b, want.b);
            if (rsp_elem_c !== want.c) report_mismatch("elem_c", rsp_elem_c, want.c);
            if (rsp_elem_d !== want.d) report_mismatch("elem_d", rsp_elem_d, want.d);
            if (rsp_degenerate !== want.deg)
               report_mismatch("degenerate", 32'(rsp_degenerate), 32'(want.deg));
            if (rsp_last_row !== want.last)
               report_mismatch("last_row", 32'(rsp_last_row), 32'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_drain_pause();
      test_random(170);
      idling_on = 1'b0;
      test_random(50);
      wait_drained();
      repeat (100) @(negedge clock);
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
